// ----- hdl/hnfr_pkg.sv -----
// Shared types, constants and the CRC-16/X.25 byte step for the HDLC NRZI frame receiver.
// No dependencies; compile first.
package hnfr_pkg;

  localparam int COUNT_WIDTH = 12;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = COUNT_WIDTH;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam count_t HEADER_BYTES = COUNT_WIDTH'(18);
  localparam count_t MIN_CHECK_BYTES = COUNT_WIDTH'(2);
  localparam count_t MIN_LEN_RESET = COUNT_WIDTH'(18);
  localparam count_t MAX_LEN_RESET = COUNT_WIDTH'(512);

  localparam logic [7:0] FLAG_PATTERN = 8'h7E;
  localparam logic [2:0] STUFF_RUN = 3'd5;
  localparam logic [2:0] RUN_SAT = 3'd7;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_CRC_ERR  = 3'd2,
    KIND_SHORT    = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MIN_FRAME_LEN = 2'd0,
    REG_MAX_FRAME_LEN = 2'd1
  } reg_index_t;

  // Reflected CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/hnfr_ifs.sv -----
// Valid/ready channel interfaces: line levels in, result items out.
// Depends on hnfr_pkg.
interface hnfr_line_if;
  logic valid;
  logic ready;
  logic line_level;
  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface hnfr_result_if;
  logic                 valid;
  logic                 ready;
  hnfr_pkg::kind_t      kind;
  logic [7:0]           data_byte;
  hnfr_pkg::count_t     byte_index;
  hnfr_pkg::count_t     info_length;
  modport source (output valid, output kind, output data_byte, output byte_index,
                  output info_length, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input info_length, output ready);
endinterface

// ----- hdl/hdlc_nrzi_frame_receiver_core.sv -----
// HDLC deframer with NRZI decoding, top level.
// Depends on hnfr_pkg and the channel interfaces in hnfr_ifs.sv.

// Each item on line_in is one demodulated line level. The level is NRZI-decoded
// (same level as before means 1), a flag 0x7E is spotted in an eight-bit window,
// stuffed zeros after five ones are dropped and the remaining bits are packed LSB
// first into bytes. Every byte leaves on result_out as a data item with its index
// in the frame; the closing flag gives one verdict: good (with the information
// length, bytes minus 18), CRC error, or too short. A frame that grows past
// max_frame_len gives an overflow item and is abandoned until the next flag.
// The FCS is CRC-16/X.25, low byte first. One line level is taken every clock
// cycle; the decode, destuff and one-byte CRC step sit between the channel and a
// single result register, and the input only stalls while that register holds
// an item the consumer has not yet taken. min_frame_len (index 0) and max_frame_len
// (index 1) are written over the cfg port; the user must write them only while the
// block is idle, a rule the block itself leaves unchecked. Other indexes are ignored.
module hdlc_nrzi_frame_receiver_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [hnfr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [hnfr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  hnfr_line_if.sink                              line_in,
  hnfr_result_if.source                          result_out
);

  // Configuration registers
  hnfr_pkg::count_t min_frame_len;
  hnfr_pkg::count_t max_frame_len;

  // Receiver state
  logic             prev_level;
  logic [7:0]       flag_window;
  logic [2:0]       ones_run;
  logic [7:0]       byte_accum;
  logic [2:0]       bit_position;
  logic             framing_active;
  hnfr_pkg::count_t frame_byte_count;
  logic [15:0]      running_crc;
  logic [7:0]       fcs_delay [2];

  logic             prev_level_next;
  logic [7:0]       flag_window_next;
  logic [2:0]       ones_run_next;
  logic [7:0]       byte_accum_next;
  logic [2:0]       bit_position_next;
  logic             framing_active_next;
  hnfr_pkg::count_t frame_byte_count_next;
  logic [15:0]      running_crc_next;
  logic [7:0]       fcs_delay_next [2];

  // Result computed for the item on the channel this cycle
  logic             res_load;
  hnfr_pkg::kind_t  res_kind;
  logic [7:0]       res_byte;
  hnfr_pkg::count_t res_index;
  hnfr_pkg::count_t res_info;

  logic             line_bit;
  logic             flag_hit;
  logic [7:0]       accum_with_bit;
  logic [15:0]      fcs_rx;
  logic             accept;

  // Result register: take a new item whenever it is empty or being drained.
  assign line_in.ready = !result_out.valid || result_out.ready;
  assign accept = line_in.valid && line_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_len <= hnfr_pkg::MIN_LEN_RESET;
      max_frame_len <= hnfr_pkg::MAX_LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        hnfr_pkg::REG_MIN_FRAME_LEN: min_frame_len <= cfg_data;
        hnfr_pkg::REG_MAX_FRAME_LEN: max_frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    line_bit = (line_in.line_level == prev_level);
    prev_level_next = line_in.line_level;
    flag_window_next = {line_bit, flag_window[7:1]};
    flag_hit = (flag_window_next == hnfr_pkg::FLAG_PATTERN);

    ones_run_next = ones_run;
    byte_accum_next = byte_accum;
    bit_position_next = bit_position;
    framing_active_next = framing_active;
    frame_byte_count_next = frame_byte_count;
    running_crc_next = running_crc;
    fcs_delay_next[0] = fcs_delay[0];
    fcs_delay_next[1] = fcs_delay[1];

    res_load = 1'b0;
    res_kind = hnfr_pkg::KIND_DATA;
    res_byte = 8'h00;
    res_index = frame_byte_count;
    res_info = '0;

    accum_with_bit = byte_accum;
    accum_with_bit[bit_position] = byte_accum[bit_position] | line_bit;
    fcs_rx = {fcs_delay[1], fcs_delay[0]};

    if (flag_hit) begin
      // Close the running frame with a verdict, unless it holds no byte.
      if (framing_active && (frame_byte_count != '0)) begin
        res_load = 1'b1;
        if ((frame_byte_count < hnfr_pkg::MIN_CHECK_BYTES) ||
            (frame_byte_count < min_frame_len)) begin
          res_kind = hnfr_pkg::KIND_SHORT;
        end else if (~running_crc == fcs_rx) begin
          res_kind = hnfr_pkg::KIND_GOOD;
          res_info = (frame_byte_count >= hnfr_pkg::HEADER_BYTES) ?
                     frame_byte_count - hnfr_pkg::HEADER_BYTES : '0;
        end else begin
          res_kind = hnfr_pkg::KIND_CRC_ERR;
        end
      end
      // Open the next frame.
      framing_active_next = 1'b1;
      frame_byte_count_next = '0;
      running_crc_next = hnfr_pkg::CRC_PRESET;
      fcs_delay_next[0] = 8'h00;
      fcs_delay_next[1] = 8'h00;
      byte_accum_next = 8'h00;
      bit_position_next = 3'd0;
      ones_run_next = 3'd0;
    end else if (framing_active) begin
      if ((ones_run == hnfr_pkg::STUFF_RUN) && !line_bit) begin
        // Drop the stuffed zero.
        ones_run_next = 3'd0;
      end else begin
        if (line_bit) begin
          ones_run_next = (ones_run == hnfr_pkg::RUN_SAT) ? ones_run : ones_run + 3'd1;
        end else begin
          ones_run_next = 3'd0;
        end
        bit_position_next = bit_position + 3'd1;
        if (bit_position == 3'd7) begin
          // Byte complete.
          byte_accum_next = 8'h00;
          res_load = 1'b1;
          if ((frame_byte_count >= max_frame_len) ||
              (frame_byte_count == hnfr_pkg::COUNT_MAX)) begin
            framing_active_next = 1'b0;
            res_kind = hnfr_pkg::KIND_OVERFLOW;
            res_index = (frame_byte_count == hnfr_pkg::COUNT_MAX) ?
                        hnfr_pkg::COUNT_MAX : frame_byte_count + hnfr_pkg::count_t'(1);
          end else begin
            res_kind = hnfr_pkg::KIND_DATA;
            res_byte = accum_with_bit;
            // The two newest bytes wait in the delay line as candidate FCS.
            if (frame_byte_count >= hnfr_pkg::MIN_CHECK_BYTES) begin
              running_crc_next = hnfr_pkg::crc_add_byte(running_crc, fcs_delay[0]);
            end
            fcs_delay_next[0] = fcs_delay[1];
            fcs_delay_next[1] = accum_with_bit;
            frame_byte_count_next = frame_byte_count + hnfr_pkg::count_t'(1);
          end
        end else begin
          byte_accum_next = accum_with_bit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      flag_window <= 8'h00;
      ones_run <= 3'd0;
      byte_accum <= 8'h00;
      bit_position <= 3'd0;
      framing_active <= 1'b0;
      frame_byte_count <= '0;
      running_crc <= hnfr_pkg::CRC_PRESET;
      fcs_delay[0] <= 8'h00;
      fcs_delay[1] <= 8'h00;
    end else if (accept) begin
      prev_level <= prev_level_next;
      flag_window <= flag_window_next;
      ones_run <= ones_run_next;
      byte_accum <= byte_accum_next;
      bit_position <= bit_position_next;
      framing_active <= framing_active_next;
      frame_byte_count <= frame_byte_count_next;
      running_crc <= running_crc_next;
      fcs_delay[0] <= fcs_delay_next[0];
      fcs_delay[1] <= fcs_delay_next[1];
    end
  end

  // Hold the result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (accept && res_load) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_load) begin
      result_out.kind <= res_kind;
      result_out.data_byte <= res_byte;
      result_out.byte_index <= res_index;
      result_out.info_length <= res_info;
    end
  end

`ifndef NO_ASSERTIONS
  // A flag always leaves a freshly opened, empty frame behind.
  a_flag_opens_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && flag_hit) |=> (framing_active && (frame_byte_count == '0) &&
                              (running_crc == hnfr_pkg::CRC_PRESET)))
    else $error("flag did not open a clean frame");

  // An overflow item abandons the frame.
  a_overflow_abandons: assert property (@(posedge clk) disable iff (rst)
    (accept && res_load && (res_kind == hnfr_pkg::KIND_OVERFLOW)) |=> !framing_active)
    else $error("frame still active after overflow");

  // Each streamed data byte advances the byte count by one.
  a_data_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && res_load && (res_kind == hnfr_pkg::KIND_DATA)) |=>
      (frame_byte_count == $past(frame_byte_count) + hnfr_pkg::count_t'(1)))
    else $error("byte count did not follow streamed byte");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for hdlc_nrzi_frame_receiver_core: line levels in, bytes and verdicts out.
// Needs hnfr_pkg and the channel interfaces from hdl/ compiled ahead of this file.
module tb_top;

  // Index that maps to no register; writes to it must leave both limits alone.
  localparam logic [hnfr_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
  // Cycles in a row with no handshake on either channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // Line levels per random traffic phase.
  localparam int PHASE_LEVELS = 48;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    hnfr_pkg::kind_t   kind;
    logic [7:0]        data_byte;
    hnfr_pkg::count_t  byte_index;
    hnfr_pkg::count_t  info_length;
  } rx_item_t;

  typedef logic [7:0] octets_t[$];

  // How the closing FCS of a generated frame is formed.
  typedef enum int {FCS_GOOD, FCS_BAD, FCS_NONE} fcs_mode_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [hnfr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [hnfr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

  hnfr_line_if   line_if ();
  hnfr_result_if result_if ();

  hdlc_nrzi_frame_receiver_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .line_in    (line_if),
    .result_out (result_if)
  );

  // Percentages of cycles in which each side holds off.
  int send_idle_pct;
  int recv_idle_pct;

  int fail_count;
  int levels_sent;
  int unsigned quiet_cycles;

  // Results still owed by the block, oldest first.
  rx_item_t pending_items[$];

  // Mirror of the receiver: limits and deframing state.
  hnfr_pkg::count_t min_len;
  hnfr_pkg::count_t max_len;
  logic             last_level;
  logic [7:0]       window;
  logic [2:0]       ones_count;
  logic [7:0]       shift_byte;
  logic [2:0]       bit_slot;
  logic             in_frame;
  hnfr_pkg::count_t byte_count;
  logic [15:0]      crc_acc;
  logic [7:0]       fcs_hold[2];

  // Transmit side: current line level and the run of data ones since the last zero.
  logic tx_level;
  int   tx_ones;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // CRC-16/X.25 over one byte, bit by bit, LSB first.
  function automatic logic [15:0] fold_fcs_byte(input logic [15:0] crc, input logic [7:0] value);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ value[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ 16'h8408;
    end
    return acc;
  endfunction

  function automatic void queue_result(input hnfr_pkg::kind_t k, input logic [7:0] d,
                                       input hnfr_pkg::count_t idx,
                                       input hnfr_pkg::count_t info);
    rx_item_t item;
    item.kind        = k;
    item.data_byte   = d;
    item.byte_index  = idx;
    item.info_length = info;
    pending_items = {pending_items, item};
  endfunction

  function automatic void reset_mirror();
    min_len     = hnfr_pkg::MIN_LEN_RESET;
    max_len     = hnfr_pkg::MAX_LEN_RESET;
    last_level  = 1'b0;
    window      = '0;
    ones_count  = '0;
    shift_byte  = '0;
    bit_slot    = '0;
    in_frame    = 1'b0;
    byte_count  = '0;
    crc_acc     = hnfr_pkg::CRC_PRESET;
    fcs_hold[0] = '0;
    fcs_hold[1] = '0;
  endfunction

  // Advance the mirror by one accepted line level and queue whatever it yields.
  function automatic void predict_level(input logic lvl);
    logic             bit_val;
    logic [7:0]       octet;
    hnfr_pkg::count_t cnt;
    bit_val    = (lvl == last_level);
    last_level = lvl;
    window     = {bit_val, window[7:1]};

    if (window == hnfr_pkg::FLAG_PATTERN) begin
      // Closing flag: a verdict only when the frame collected something.
      if (in_frame && byte_count != '0) begin
        cnt = byte_count;
        if (cnt < hnfr_pkg::MIN_CHECK_BYTES || cnt < min_len)
          queue_result(hnfr_pkg::KIND_SHORT, 8'h00, cnt, '0);
        else if ((~crc_acc) == {fcs_hold[1], fcs_hold[0]})
          queue_result(hnfr_pkg::KIND_GOOD, 8'h00, cnt,
                       (cnt >= hnfr_pkg::HEADER_BYTES) ? cnt - hnfr_pkg::HEADER_BYTES : '0);
        else
          queue_result(hnfr_pkg::KIND_CRC_ERR, 8'h00, cnt, '0);
      end
      in_frame    = 1'b1;
      byte_count  = '0;
      crc_acc     = hnfr_pkg::CRC_PRESET;
      fcs_hold[0] = '0;
      fcs_hold[1] = '0;
      shift_byte  = '0;
      bit_slot    = '0;
      ones_count  = '0;
      return;
    end

    if (!in_frame) return;

    // Drop the zero stuffed after five ones.
    if (ones_count == hnfr_pkg::STUFF_RUN && !bit_val) begin
      ones_count = '0;
      return;
    end
    if (bit_val) begin
      if (ones_count < hnfr_pkg::RUN_SAT) ones_count = ones_count + 3'd1;
    end else begin
      ones_count = '0;
    end

    shift_byte[bit_slot] = bit_val;
    bit_slot = bit_slot + 3'd1;
    if (bit_slot != 3'd0) return;

    octet      = shift_byte;
    shift_byte = '0;
    cnt        = byte_count;

    if (cnt >= max_len || cnt >= hnfr_pkg::COUNT_MAX) begin
      in_frame = 1'b0;
      queue_result(hnfr_pkg::KIND_OVERFLOW, 8'h00,
                   (cnt >= hnfr_pkg::COUNT_MAX) ? hnfr_pkg::COUNT_MAX :
                                                 cnt + hnfr_pkg::count_t'(1), '0);
      return;
    end

    queue_result(hnfr_pkg::KIND_DATA, octet, cnt, '0);
    // The newest two bytes may be the FCS; fold a byte in only once it is pushed out.
    if (cnt >= hnfr_pkg::MIN_CHECK_BYTES) crc_acc = fold_fcs_byte(crc_acc, fcs_hold[0]);
    fcs_hold[0] = fcs_hold[1];
    fcs_hold[1] = octet;
    byte_count  = cnt + hnfr_pkg::count_t'(1);
  endfunction

  // Offer one line level; entered and left just after a falling edge.
  // valid stays high on return so that back-to-back items need no second assignment.
  task automatic send_level(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      line_if.valid <= 1'b0;
      @(negedge clk);
    end
    line_if.valid      <= 1'b1;
    line_if.line_level <= lvl;
    @(posedge clk);
    while (!line_if.ready) @(posedge clk);
    predict_level(lvl);
    levels_sent++;
    @(negedge clk);
  endtask

  // NRZI on the wire: a zero toggles the level, a one holds it.
  task automatic send_raw_bit(input logic value);
    if (!value) tx_level = ~tx_level;
    send_level(tx_level);
  endtask

  task automatic send_data_bit(input logic value);
    send_raw_bit(value);
    if (value) begin
      tx_ones++;
      if (tx_ones == 5) begin
        send_raw_bit(1'b0);
        tx_ones = 0;
      end
    end else begin
      tx_ones = 0;
    end
  endtask

  task automatic send_octet(input logic [7:0] value);
    for (int i = 0; i < 8; i++) send_data_bit(value[i]);
  endtask

  task automatic send_flag();
    for (int i = 0; i < 8; i++) send_raw_bit(hnfr_pkg::FLAG_PATTERN[i]);
    tx_ones = 0;
  endtask

  // One frame: optional opening flag, payload, FCS as asked, stray bits, closing flag.
  task automatic send_frame(input octets_t payload, input fcs_mode_t mode, input int stray_bits,
                            input bit lead_flag);
    logic [15:0] crc;
    logic [15:0] fcs;
    if (lead_flag) send_flag();
    crc = hnfr_pkg::CRC_PRESET;
    foreach (payload[i]) begin
      crc = fold_fcs_byte(crc, payload[i]);
      send_octet(payload[i]);
    end
    fcs = ~crc;
    if (mode == FCS_BAD) fcs = fcs ^ (16'h0001 << $urandom_range(15));
    if (mode != FCS_NONE) begin
      send_octet(fcs[7:0]);
      send_octet(fcs[15:8]);
    end
    repeat (stray_bits) send_data_bit(1'($urandom_range(1)));
    send_flag();
  endtask

  function automatic octets_t random_payload(input int n);
    octets_t q;
    repeat (n) q = {q, 8'($urandom_range(255))};
    return q;
  endfunction

  // Drop valid, let every owed result arrive, then allow for the result register.
  task automatic wait_idle();
    line_if.valid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Only called while the block is idle; the mirror takes the value at once.
  task automatic write_register(input logic [hnfr_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                input logic [hnfr_pkg::CFG_DATA_WIDTH-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == hnfr_pkg::REG_MIN_FRAME_LEN) min_len = value;
    else if (idx == hnfr_pkg::REG_MAX_FRAME_LEN) max_len = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Flags outside a frame and back to back, then verdicts under the reset limits.
  task automatic test_frame_verdicts();
    octets_t payload;
    send_flag();
    send_flag();
    // Shortest frame that passes the reset minimum: 16 bytes plus FCS, info length zero.
    // 0xFF and 0x7E force stuffed zeros.
    payload = {8'h00, 8'hFF, 8'h7E, 8'hF8, 8'h1F};
    payload = {payload, random_payload(11)};
    send_frame(payload, FCS_GOOD, 0, 1'b0);
    send_frame(random_payload(17), FCS_GOOD, 0, 1'b0);
    // A lone byte with no FCS: below both the floor of two and the minimum.
    send_frame(random_payload(1), FCS_NONE, 0, 1'b0);
    // Leftover bits before the flag are thrown away.
    send_frame(random_payload(4), FCS_GOOD, 5, 1'b0);
    // Long run of ones inside a frame; the run counter saturates.
    send_octet(8'hA5);
    repeat (9) send_raw_bit(1'b1);
    tx_ones = 0;
    send_octet(8'h3C);
    send_octet(8'h00);
    send_flag();
    wait_idle();
  endtask

  // Limits near their extremes: overflow at a maximum of two, everything short at a minimum of 4094.
  task automatic test_register_limits();
    write_register(hnfr_pkg::REG_MIN_FRAME_LEN, 12'd2);
    write_register(hnfr_pkg::REG_MAX_FRAME_LEN, 12'd2);
    send_flag();
    send_frame(random_payload(0), FCS_GOOD, 0, 1'b0);
    send_frame(random_payload(1), FCS_NONE, 0, 1'b0);
    // Third byte is past the maximum: overflow, then no verdict at the next flag.
    send_frame(random_payload(1), FCS_GOOD, 0, 1'b0);
    send_frame(random_payload(4), FCS_GOOD, 3, 1'b0);
    wait_idle();
    // Unknown index: the limits must not move.
    write_register(REG_UNUSED, 12'hFFF);
    send_frame(random_payload(0), FCS_GOOD, 0, 1'b1);
    wait_idle();
    write_register(hnfr_pkg::REG_MIN_FRAME_LEN, 12'd4094);
    write_register(hnfr_pkg::REG_MAX_FRAME_LEN, 12'd4094);
    send_frame(random_payload(2), FCS_GOOD, 0, 1'b1);
    send_frame(random_payload(1), FCS_BAD, 0, 1'b0);
    wait_idle();
  endtask

  // Mostly well-formed frames with random content, mixed with noise, bad FCS,
  // stray bits, empty frames and runs of ones.
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    int start;
    int pick;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    write_register(hnfr_pkg::REG_MIN_FRAME_LEN, 12'($urandom_range(2, 14)));
    write_register(hnfr_pkg::REG_MAX_FRAME_LEN, 12'($urandom_range(2, 20)));
    start = levels_sent;
    send_flag();
    while (levels_sent - start < PHASE_LEVELS) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame(random_payload($urandom_range(0, 10)), FCS_GOOD, 0, 1'($urandom_range(1)));
      end else if (pick < 70) begin
        send_frame(random_payload($urandom_range(0, 10)), FCS_BAD, 0, 1'($urandom_range(1)));
      end else if (pick < 78) begin
        send_frame(random_payload($urandom_range(0, 6)), FCS_GOOD, $urandom_range(1, 7), 1'b0);
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 24)) begin
          tx_level = 1'($urandom_range(1));
          send_level(tx_level);
        end
        tx_ones = 0;
        send_flag();
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 3)) send_flag();
      end else begin
        send_flag();
        send_octet(8'($urandom_range(255)));
        repeat ($urandom_range(6, 12)) send_raw_bit(1'b1);
        tx_ones = 0;
        send_frame(random_payload($urandom_range(0, 4)), FCS_GOOD, 0, 1'b0);
      end
    end
    wait_idle();
  endtask

  // Consumer: hold off at random, changing only on the falling edge.
  always @(negedge clk) begin
    if (rst) result_if.ready <= 1'b0;
    else result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest one owed.
  always @(posedge clk) begin
    rx_item_t got;
    rx_item_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got.kind        = result_if.kind;
      got.data_byte   = result_if.data_byte;
      got.byte_index  = result_if.byte_index;
      got.info_length = result_if.info_length;
      if (pending_items.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected result kind=%0d data=%02h index=%0d info=%0d", $realtime,
                   got.kind, got.data_byte, got.byte_index, got.info_length);
      end else begin
        want = pending_items.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.byte_index !== want.byte_index || got.info_length !== want.info_length) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"%0t: mismatch expected kind=%0d data=%02h index=%0d info=%0d, ",
                      "%s%0d %s%02h %s%0d %s%0d"},
                     $realtime, want.kind, want.data_byte, want.byte_index, want.info_length,
                     "got kind=", got.kind, "data=", got.data_byte, "index=", got.byte_index,
                     "info=", got.info_length);
        end
      end
    end
  end

  // Hang detector: any handshake on either channel clears the count.
  always @(posedge clk) begin
    if (rst || (line_if.valid && line_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    line_if.valid      = 1'b0;
    line_if.line_level = 1'b0;
    result_if.ready    = 1'b0;
    fail_count         = 0;
    levels_sent        = 0;
    quiet_cycles       = 0;
    tx_level           = 1'b0;
    tx_ones            = 0;
    send_idle_pct      = 32;
    recv_idle_pct      = 68;
    reset_mirror();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_frame_verdicts();
    test_register_limits();
    test_random_traffic(32, 68);
    test_random_traffic(68, 32);
    test_random_traffic(0, 0);

    if (fail_count == 0 && pending_items.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
